[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define FAA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define FAA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/faa_pkg.sv]
// ----------------------------------------------------------------------------
// faa_pkg
// Shared widths, defaults and codes of the finite automaton acceptor.
// ----------------------------------------------------------------------------
package faa_pkg;

   // Default sizing of the automaton.
   localparam int NUM_STATES_DEF    = 32;
   localparam int ALPHABET_SIZE_DEF = 16;

   // Request and response field widths.
   localparam int MODE_W      = 2;
   localparam int STATE_IDX_W = 5;
   localparam int SYMBOL_W    = 4;

   // Register port widths.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int MASK_W     = 32;

   // Request kinds.
   typedef enum logic [MODE_W-1:0] {
      MODE_SYMBOL    = 2'd0,
      MODE_END       = 2'd1,
      MODE_ADD_TRANS = 2'd2,
      MODE_ADD_EPS   = 2'd3
   } mode_type;

   // Register indexes, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_DETERMINISTIC = 2'd0,
      REG_START_STATE   = 2'd1,
      REG_ACCEPT_MASK   = 2'd2
   } csr_index_type;

endpackage

[hdl/faa_channels.sv]
// ----------------------------------------------------------------------------
// faa_channels
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------

// Request channel: one symbol, end of string or table edit per request.
interface faa_req_if;
   import faa_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [MODE_W-1:0]      mode;
   logic [STATE_IDX_W-1:0] state_from;
   logic [SYMBOL_W-1:0]    symbol;
   logic [STATE_IDX_W-1:0] state_to;

   modport source (output valid, mode, state_from, symbol, state_to, input ready);
   modport sink   (input valid, mode, state_from, symbol, state_to, output ready);
endinterface

// Response channel: one verdict per finished string.
interface faa_rsp_if;
   logic valid;
   logic ready;
   logic accepted;
   logic died_early;

   modport source (output valid, accepted, died_early, input ready);
   modport sink   (input valid, accepted, died_early, output ready);
endinterface

[hdl/finite_automaton_acceptor.sv]
// ----------------------------------------------------------------------------
// finite_automaton_acceptor
// Runs strings through an automaton with optional epsilon edges held in
// two synchronous tables, one symbol request at a time.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake             Carries
//   req_chan   in         valid/ready           mode, state_from, symbol, state_to
//   rsp_chan   out        valid/ready           accepted, died_early
//   APB        in/out     psel/penable, pready  deterministic, start index, accept mask
//
// After reset a clearing pass over all NUM_STATES*ALPHABET_SIZE entries (512 by default)
// zeroes both tables; no request is taken meanwhile.
// A table edit steps through accept, read and write back.
// A symbol runs a successor scan over the active states and, without the
// deterministic flag, an epsilon closure over the newly reached states,
// each at one table read per cycle. Arming adds one closure.
// A verdict waits in the output register while new requests are accepted.
// ----------------------------------------------------------------------------
module finite_automaton_acceptor #(
   parameter int NUM_STATES    = faa_pkg::NUM_STATES_DEF,
   parameter int ALPHABET_SIZE = faa_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   faa_req_if.sink                        req_chan,
   faa_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [faa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [faa_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [faa_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import faa_pkg::*;

   localparam int TABLE_DEPTH = NUM_STATES * ALPHABET_SIZE;
   localparam int SW          = $clog2(NUM_STATES);
   localparam int TAW         = $clog2(TABLE_DEPTH);

   typedef logic [NUM_STATES-1:0] set_type;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_ADD_RD = 7'b0000100,
      ST_ADD_WR = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_CLOSE  = 7'b0100000,
      ST_REPORT = 7'b1000000
   } fsm_type;

   // Table address of a (state, symbol) entry.
   function automatic logic [TAW-1:0] tbl_addr(input logic [SW-1:0] s,
                                               input logic [SYMBOL_W-1:0] y);
      return TAW'(s) * TAW'(ALPHABET_SIZE) + TAW'(y);
   endfunction

   // Configuration registers.
   logic                   det_ff;
   logic [STATE_IDX_W-1:0] start_ff;
   logic [MASK_W-1:0]      amask_ff;

   // Control and run state.
   fsm_type                state_ff, state_in;
   logic [TAW-1:0]         clr_cnt_ff, clr_cnt_in;
   mode_type               mode_ff, mode_in;
   logic [STATE_IDX_W-1:0] from_ff, from_in;
   logic [SYMBOL_W-1:0]    sym_ff, sym_in;
   logic [STATE_IDX_W-1:0] to_ff, to_in;
   set_type                active_ff, active_in;
   logic                   started_ff, started_in;
   logic                   dead_ff, dead_in;
   set_type                pending_ff, pending_in;
   logic                   inflight_ff, inflight_in;
   set_type                next_ff, next_in;
   logic                   arm_ff, arm_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_acc_ff, rsp_acc_in;
   logic                   rsp_died_ff, rsp_died_in;

   // Table memories and their ports.
   set_type                trans_mem [TABLE_DEPTH];
   set_type                eps_mem [NUM_STATES];
   set_type                trans_rdata_ff;
   set_type                eps_rdata_ff;
   logic                   trans_re, trans_we;
   logic [TAW-1:0]         trans_raddr, trans_waddr;
   set_type                trans_wdata;
   logic                   eps_re, eps_we;
   logic [SW-1:0]          eps_raddr, eps_waddr;
   set_type                eps_wdata;

   // Helper values.
   set_type                pick_oh;
   logic [SW-1:0]          pick_idx;
   logic                   busy;
   set_type                start_set;
   set_type                to_oh;
   set_type                amask_ext;
   set_type                eps_data;
   logic                   req_sym_ok, sym_ok, from_ok, to_ok;
   mode_type               req_mode;
   csr_index_type          csr_index;

   // Accepting mask, widened or cut to the state count.
   for (genvar g = 0; g < NUM_STATES; g++) begin : g_amask
      if (g < MASK_W) begin : g_in
         assign amask_ext[g] = amask_ff[g];
      end else begin : g_out
         assign amask_ext[g] = 1'b0;
      end
   end

   // Lowest pending state: isolate the bit, then encode it.
   always_comb begin
      pick_oh  = pending_ff & (~pending_ff + NUM_STATES'(1));
      pick_idx = '0;
      for (int i = 0; i < NUM_STATES; i++) begin
         if (pick_oh[i]) begin
            pick_idx = pick_idx | SW'(i);
         end
      end
   end

   assign busy       = (|pending_ff) | inflight_ff;
   assign start_set  = (32'(start_ff) < 32'(NUM_STATES)) ?
                       (NUM_STATES'(1) << start_ff) : '0;
   assign to_oh      = NUM_STATES'(1) << to_ff;
   assign req_mode   = mode_type'(req_chan.mode);
   assign req_sym_ok = 32'(req_chan.symbol) < 32'(ALPHABET_SIZE);
   assign sym_ok     = 32'(sym_ff) < 32'(ALPHABET_SIZE);
   assign from_ok    = 32'(req_chan.state_from) < 32'(NUM_STATES);
   assign to_ok      = 32'(req_chan.state_to) < 32'(NUM_STATES);
   assign eps_data   = inflight_ff ? eps_rdata_ff : '0;

   // Memory addresses and write data.
   assign trans_raddr = (state_ff == ST_SCAN) ? tbl_addr(pick_idx, sym_ff) :
                        tbl_addr(SW'(from_ff), sym_ff);
   assign eps_raddr   = (state_ff == ST_CLOSE) ? pick_idx : SW'(from_ff);
   assign trans_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff :
                        tbl_addr(SW'(from_ff), sym_ff);
   assign eps_waddr   = (state_ff == ST_CLEAR) ? clr_cnt_ff[SW-1:0] : SW'(from_ff);
   assign trans_wdata = (state_ff == ST_CLEAR) ? '0 : (trans_rdata_ff | to_oh);
   assign eps_wdata   = (state_ff == ST_CLEAR) ? '0 : (eps_rdata_ff | to_oh);

   // Main sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      mode_in      = mode_ff;
      from_in      = from_ff;
      sym_in       = sym_ff;
      to_in        = to_ff;
      active_in    = active_ff;
      started_in   = started_ff;
      dead_in      = dead_ff;
      pending_in   = pending_ff;
      inflight_in  = 1'b0;
      next_in      = next_ff;
      arm_in       = arm_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_died_in  = rsp_died_ff;
      trans_re     = 1'b0;
      trans_we     = 1'b0;
      eps_re       = 1'b0;
      eps_we       = 1'b0;

      unique case (state_ff)
         // Zero both tables, one entry per cycle.
         ST_CLEAR: begin
            trans_we = 1'b1;
            eps_we   = 32'(clr_cnt_ff) < 32'(NUM_STATES);
            if (clr_cnt_ff == TAW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + TAW'(1);
            end
         end

         // Take a request and decide the work it needs.
         ST_IDLE: begin
            if (req_chan.valid) begin
               mode_in = req_mode;
               from_in = req_chan.state_from;
               sym_in  = req_chan.symbol;
               to_in   = req_chan.state_to;
               unique case (req_mode)
                  MODE_SYMBOL: begin
                     next_in = '0;
                     if (!started_ff) begin
                        active_in  = start_set;
                        started_in = 1'b1;
                        dead_in    = 1'b0;
                        if (det_ff) begin
                           state_in   = ST_SCAN;
                           pending_in = req_sym_ok ? start_set : '0;
                        end else begin
                           state_in   = ST_CLOSE;
                           pending_in = start_set;
                           arm_in     = 1'b1;
                        end
                     end else if (!dead_ff) begin
                        state_in   = ST_SCAN;
                        pending_in = req_sym_ok ? active_ff : '0;
                     end
                  end
                  MODE_END: begin
                     if (!started_ff) begin
                        active_in  = start_set;
                        started_in = 1'b1;
                        dead_in    = 1'b0;
                        if (det_ff) begin
                           state_in = ST_REPORT;
                        end else begin
                           state_in   = ST_CLOSE;
                           pending_in = start_set;
                           arm_in     = 1'b1;
                        end
                     end else begin
                        state_in = ST_REPORT;
                     end
                  end
                  MODE_ADD_TRANS: begin
                     if (from_ok && to_ok && req_sym_ok) begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  MODE_ADD_EPS: begin
                     if (from_ok && to_ok) begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         // Read the entry to be extended.
         ST_ADD_RD: begin
            if (mode_ff == MODE_ADD_TRANS) begin
               trans_re = 1'b1;
            end else begin
               eps_re = 1'b1;
            end
            state_in = ST_ADD_WR;
         end

         // Write it back with the new target; deterministic mode keeps a filled transition entry.
         ST_ADD_WR: begin
            if (mode_ff == MODE_ADD_TRANS) begin
               trans_we = !(det_ff && (|trans_rdata_ff));
            end else begin
               eps_we = 1'b1;
            end
            state_in = ST_IDLE;
         end

         // Unite the successors of every active state, one row read per cycle.
         ST_SCAN: begin
            trans_re    = |pending_ff;
            inflight_in = |pending_ff;
            pending_in  = pending_ff & ~pick_oh;
            if (inflight_ff) begin
               next_in = next_ff | trans_rdata_ff;
            end
            if (!busy) begin
               if (next_ff == '0) begin
                  dead_in   = 1'b1;
                  active_in = '0;
                  state_in  = ST_IDLE;
               end else begin
                  active_in = next_ff;
                  if (det_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in   = ST_CLOSE;
                     pending_in = next_ff;
                     arm_in     = 1'b0;
                  end
               end
            end
         end

         // Epsilon closure: expand each newly reached state exactly once.
         ST_CLOSE: begin
            eps_re      = |pending_ff;
            inflight_in = |pending_ff;
            active_in   = active_ff | eps_data;
            pending_in  = (pending_ff & ~pick_oh) | (eps_data & ~active_ff);
            if (!busy) begin
               arm_in = 1'b0;
               if (mode_ff == MODE_END) begin
                  state_in = ST_REPORT;
               end else if (arm_ff) begin
                  state_in   = ST_SCAN;
                  pending_in = sym_ok ? active_ff : '0;
                  next_in    = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         // Hand the verdict to the output register once it is free, then rearm.
         ST_REPORT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = !dead_ff && (|(active_ff & amask_ext));
               rsp_died_in  = dead_ff;
               active_in    = '0;
               started_in   = 1'b0;
               dead_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         active_ff    <= '0;
         started_ff   <= 1'b0;
         dead_ff      <= 1'b0;
         pending_ff   <= '0;
         inflight_ff  <= 1'b0;
         arm_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         active_ff    <= active_in;
         started_ff   <= started_in;
         dead_ff      <= dead_in;
         pending_ff   <= pending_in;
         inflight_ff  <= inflight_in;
         arm_ff       <= arm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      from_ff     <= from_in;
      sym_ff      <= sym_in;
      to_ff       <= to_in;
      next_ff     <= next_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_died_ff <= rsp_died_in;
   end

   // Transition table memory.
   always_ff @(posedge clock) begin
      if (trans_we) begin
         trans_mem[trans_waddr] <= trans_wdata;
      end
      if (trans_re) begin
         trans_rdata_ff <= trans_mem[trans_raddr];
      end
   end

   // Epsilon table memory.
   always_ff @(posedge clock) begin
      if (eps_we) begin
         eps_mem[eps_waddr] <= eps_wdata;
      end
      if (eps_re) begin
         eps_rdata_ff <= eps_mem[eps_raddr];
      end
   end

   // Register port: writes and reads.
   assign csr_index = csr_index_type'(paddr[3:2]);
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_ff   <= 1'b0;
         start_ff <= '0;
         amask_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (csr_index)
            REG_DETERMINISTIC: det_ff   <= pwdata[0];
            REG_START_STATE:   start_ff <= pwdata[STATE_IDX_W-1:0];
            REG_ACCEPT_MASK:   amask_ff <= pwdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DETERMINISTIC: prdata = {{(CSR_DATA_W-1){1'b0}}, det_ff};
         REG_START_STATE:   prdata = {{(CSR_DATA_W-STATE_IDX_W){1'b0}}, start_ff};
         REG_ACCEPT_MASK:   prdata = amask_ff;
         default:           prdata = '0;
      endcase
   end

   // Channel outputs.
   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.accepted   = rsp_acc_ff;
   assign rsp_chan.died_early = rsp_died_ff;

endmodule

[hdl/faa_checker.sv]
// ----------------------------------------------------------------------------
// faa_checker
// Port-level checks of the finite automaton acceptor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module faa_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_accepted,
   input logic rsp_died_early
);

   // A stalled response stays offered.
   `FAA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // A stalled response keeps its verdict.
   `FAA_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_accepted) && $stable(rsp_died_early), "response changed while stalled")

   // A run that died is never reported as accepted.
   `FAA_ASSERT(a_dead_rejects, clock, reset, rsp_valid |-> !(rsp_accepted && rsp_died_early), "dead run reported as accepted")

   // The table clearing pass keeps requests out right after reset.
   `FAA_ASSERT_ALWAYS(a_clear_blocks, clock, $past(reset) |-> !req_ready, "request taken during table clearing")

endmodule

bind finite_automaton_acceptor faa_checker u_faa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_accepted   (rsp_chan.accepted),
   .rsp_died_early (rsp_chan.died_early)
);
